// ===== src/skt_pkg.sv =====
package skt_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  localparam int unsigned CapW = 6;
  localparam logic [CapW-1:0] CAP_RESET = 6'd32;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic [31:0]        handle;
    logic [4:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic [31:0]        out_handle;
    logic [5:0]         entry_count;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        handle;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic set_full;
    logic set_bad;
    logic ins_init;
    logic ins_shift;
    logic ins_place;
    logic rd_idx;
    logic take;
    logic rm_shift;
    logic dec_count;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       bad_index;
    logic       cnt_zero;
    logic       key_less;
    logic       ptr_is_one;
    logic       more_first;
    logic       more_step;
  } stat_t;

endpackage

// ===== src/skt_ctrl.sv =====
module skt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  skt_pkg::stat_t stat_i,
  output skt_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DECODE    = 4'd1;
  localparam logic [3:0] ST_INS_STEP  = 4'd2;
  localparam logic [3:0] ST_INS_PLACE = 4'd3;
  localparam logic [3:0] ST_GET_RD    = 4'd4;
  localparam logic [3:0] ST_RM_FIRST  = 4'd5;
  localparam logic [3:0] ST_RM_STEP   = 4'd6;
  localparam logic [3:0] ST_FINISH    = 4'd7;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.op)
          skt_pkg::OP_INSERT: begin
            if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
              state_d        = ST_FINISH;
            end else begin
              cmd_o.ins_init = 1'b1;
              state_d        = stat_i.cnt_zero ? ST_INS_PLACE : ST_INS_STEP;
            end
          end
          skt_pkg::OP_GET, skt_pkg::OP_REMOVE: begin
            if (stat_i.bad_index) begin
              cmd_o.set_bad = 1'b1;
              state_d       = ST_FINISH;
            end else begin
              cmd_o.rd_idx = 1'b1;
              state_d      = (stat_i.op == skt_pkg::OP_GET) ? ST_GET_RD : ST_RM_FIRST;
            end
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_INS_STEP: begin
        if (stat_i.key_less) begin
          cmd_o.ins_place = 1'b1;
          state_d         = ST_FINISH;
        end else begin
          cmd_o.ins_shift = 1'b1;
          state_d         = stat_i.ptr_is_one ? ST_INS_PLACE : ST_INS_STEP;
        end
      end
      ST_INS_PLACE: begin
        cmd_o.ins_place = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_GET_RD: begin
        cmd_o.take = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_RM_FIRST: begin
        cmd_o.take = 1'b1;
        if (stat_i.more_first) begin
          state_d = ST_RM_STEP;
        end else begin
          cmd_o.dec_count = 1'b1;
          state_d         = ST_FINISH;
        end
      end
      ST_RM_STEP: begin
        cmd_o.rm_shift = 1'b1;
        if (!stat_i.more_step) begin
          cmd_o.dec_count = 1'b1;
          state_d         = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/skt_datapath.sv =====
module skt_datapath #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  skt_pkg::in_item_t          in_item_i,
  input  logic                       cfg_we_i,
  input  logic [skt_pkg::CapW-1:0]   cfg_data_i,
  input  skt_pkg::cmd_t              cmd_i,
  output skt_pkg::stat_t             stat_o,
  output skt_pkg::out_item_t         out_item_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > skt_pkg::CapW) ? CW : skt_pkg::CapW;

  skt_pkg::entry_t mem [DEPTH];

  skt_pkg::in_item_t          item_q;
  skt_pkg::entry_t            rd_q;
  skt_pkg::out_item_t         out_q;
  logic [skt_pkg::CapW-1:0]   cap_q;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              ptr_q, ptr_d;
  logic [1:0]                 res_status_q, res_status_d;
  skt_pkg::entry_t            res_q, res_d;
  logic [CMPW-1:0]            idx_ext;
  logic                       rd_en, wr_en;
  logic [AW-1:0]              rd_addr, wr_addr;
  skt_pkg::entry_t            wr_data;

  assign idx_ext = CMPW'(item_q.index);

  always_comb begin
    stat_o.op         = item_q.op;
    stat_o.full       = (count_q == CW'(DEPTH)) || (CMPW'(count_q) >= CMPW'(cap_q));
    stat_o.bad_index  = idx_ext >= CMPW'(count_q);
    stat_o.cnt_zero   = (count_q == '0);
    stat_o.key_less   = rd_q.key < item_q.key;
    stat_o.ptr_is_one = (ptr_q == CW'(1));
    stat_o.more_first = (idx_ext + CMPW'(1)) < CMPW'(count_q);
    stat_o.more_step  = (count_q - ptr_q) > CW'(2);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = ptr_q[AW-1:0];
    wr_data = rd_q;
    ptr_d   = ptr_q;
    count_d = count_q;
    if (cmd_i.ins_init) begin
      ptr_d   = count_q;
      rd_en   = !stat_o.cnt_zero;
      rd_addr = AW'(count_q - CW'(1));
    end
    if (cmd_i.ins_shift) begin
      wr_en   = 1'b1;
      ptr_d   = ptr_q - CW'(1);
      rd_en   = !stat_o.ptr_is_one;
      rd_addr = AW'(ptr_q - CW'(2));
    end
    if (cmd_i.ins_place) begin
      wr_en       = 1'b1;
      wr_data.key = item_q.key;
      wr_data.handle = item_q.handle;
      count_d     = count_q + CW'(1);
    end
    if (cmd_i.rd_idx) begin
      rd_en   = 1'b1;
      rd_addr = AW'(item_q.index);
    end
    if (cmd_i.take) begin
      ptr_d   = CW'(item_q.index);
      rd_en   = stat_o.more_first;
      rd_addr = AW'(idx_ext + CMPW'(1));
    end
    if (cmd_i.rm_shift) begin
      wr_en   = 1'b1;
      ptr_d   = ptr_q + CW'(1);
      rd_en   = stat_o.more_step;
      rd_addr = AW'(ptr_q + CW'(2));
    end
    if (cmd_i.dec_count) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    res_status_d = res_status_q;
    res_d        = res_q;
    if (cmd_i.latch) begin
      res_status_d = skt_pkg::STATUS_OK;
      res_d        = '0;
    end
    if (cmd_i.set_full) begin
      res_status_d = skt_pkg::STATUS_FULL;
    end
    if (cmd_i.set_bad) begin
      res_status_d = skt_pkg::STATUS_BAD_INDEX;
    end
    if (cmd_i.take) begin
      res_d = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    if (cmd_i.load_out) begin
      out_q.status      <= res_status_q;
      out_q.out_key     <= res_q.key;
      out_q.out_handle  <= res_q.handle;
      out_q.entry_count <= 6'(count_q);
    end
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_q        <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= skt_pkg::CAP_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== src/sorted_key_table.sv =====
// Sorted key table: holds up to DEPTH entries of a signed key and a handle in
// ascending key order, with insert, get by index and remove by index.
// The in channel (in_valid_i, in_ready_o, in_item_i) takes one item at a time;
// every item yields exactly one result item on the out channel (out_valid_o,
// out_ready_i, out_item_o), carrying status and the entry count afterwards.
// An insert or a remove shifts entries along the table, one entry per cycle,
// since the entries live in a single memory with one read and one write port.
// A get, a refused insert, a bad index and the unused op shift nothing. A new
// item is taken once the previous one has finished.
// The cfg channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the capacity
// register at any time; it is always ready and should be used while idle.
// Reset empties the table and sets the capacity to 32. Memory contents are
// not cleared, because only entries below the count are ever read.
// If the receiver stalls, the finished result waits in the output register,
// the next item is still accepted and worked on, and its result waits until
// the output register has been emptied.
module sorted_key_table #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  skt_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output skt_pkg::out_item_t        out_item_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [skt_pkg::CapW-1:0]  cfg_data_i
);

  skt_pkg::cmd_t  cmd;
  skt_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  skt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

// ===== src/skt_checker.sv =====
module skt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input skt_pkg::out_item_t        out_item_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result item changed or was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Block took a second item while one was being worked on.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status == skt_pkg::STATUS_OK ||
                    out_item_o.status == skt_pkg::STATUS_FULL ||
                    out_item_o.status == skt_pkg::STATUS_BAD_INDEX)
    else $error("Result item carries an undefined status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != skt_pkg::STATUS_OK |->
      out_item_o.out_key == '0 && out_item_o.out_handle == '0)
    else $error("Refused item returned a nonzero entry.");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== sim/tb_sorted_key_table.sv =====
module tb_sorted_key_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PhaseItems = 175;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 40;

  class table_scoreboard;
    logic signed [31:0]       keys [TableDepth];
    logic [31:0]              handles [TableDepth];
    int unsigned              count;
    logic [skt_pkg::CapW-1:0] capacity;
    skt_pkg::out_item_t       pending_results [$];
    int unsigned              errors;

    function new();
      count = 0;
      capacity = skt_pkg::CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(input logic [skt_pkg::CapW-1:0] value);
      capacity = value;
    endfunction

    function int unsigned limit();
      return (32'(capacity) < TableDepth) ? 32'(capacity) : TableDepth;
    endfunction

    function skt_pkg::out_item_t predict_table_op(input skt_pkg::in_item_t it);
      skt_pkg::out_item_t res;
      int unsigned        pos;
      int unsigned        i;
      logic signed [31:0] new_key;
      res = '0;
      res.status = skt_pkg::STATUS_OK;
      new_key = it.key;
      case (it.op)
        skt_pkg::OP_INSERT: begin
          if (count >= limit()) begin
            res.status = skt_pkg::STATUS_FULL;
          end else begin
            pos = 0;
            while (pos < count && keys[pos] < new_key) pos++;
            for (i = count; i > pos; i--) begin
              keys[i] = keys[i-1];
              handles[i] = handles[i-1];
            end
            keys[pos] = new_key;
            handles[pos] = it.handle;
            count++;
          end
        end
        skt_pkg::OP_GET, skt_pkg::OP_REMOVE: begin
          if (32'(it.index) >= count) begin
            res.status = skt_pkg::STATUS_BAD_INDEX;
          end else begin
            res.out_key = keys[it.index];
            res.out_handle = handles[it.index];
            if (it.op == skt_pkg::OP_REMOVE) begin
              for (i = 32'(it.index); i + 1 < count; i++) begin
                keys[i] = keys[i+1];
                handles[i] = handles[i+1];
              end
              count--;
            end
          end
        end
        default: begin
        end
      endcase
      res.entry_count = count[5:0];
      return res;
    endfunction

    function void note_request(input skt_pkg::in_item_t it);
      pending_results.push_back(predict_table_op(it));
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_response(input skt_pkg::out_item_t got);
      skt_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result item, status %0d count %0d",
                         got.status, got.entry_count));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.out_key !== want.out_key)
        report($sformatf("out_key %0d, expected %0d", got.out_key, want.out_key));
      if (got.out_handle !== want.out_handle)
        report($sformatf("out_handle %h, expected %h", got.out_handle, want.out_handle));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count %0d, expected %0d", got.entry_count,
                         want.entry_count));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  skt_pkg::in_item_t        in_item_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  skt_pkg::out_item_t       out_item_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [skt_pkg::CapW-1:0] cfg_data_i;

  table_scoreboard sb;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  logic            hold_req;
  logic            hold_ack;
  int unsigned     hold_left;
  bit              filling;

  sorted_key_table #(
    .DEPTH(TableDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    hold_req = 1'b0;
    hold_ack = 1'b0;
    hold_left = 0;
    tx_idle_pct = 12;
    rx_idle_pct = 50;
    filling = 1'b1;
    sb = new();
  end

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_response(out_item_o);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(input skt_pkg::in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(it);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [31:0] key,
                         input logic [31:0] handle, input logic [4:0] index);
    skt_pkg::in_item_t it;
    it.op = op;
    it.key = key;
    it.handle = handle;
    it.index = index;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [skt_pkg::CapW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_capacity(value);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return int'($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic skt_pkg::in_item_t random_item();
    skt_pkg::in_item_t it;
    int unsigned       cnt;
    int unsigned       roll;
    cnt = sb.count;
    if (cnt == 0) filling = 1'b1;
    else if (cnt >= sb.limit() && $urandom_range(0, 3) == 0) filling = 1'b0;
    else if ($urandom_range(0, 49) == 0) filling = !filling;
    it.key = pick_key();
    it.handle = $urandom();
    if (cnt > 0 && $urandom_range(0, 99) < 85) it.index = 5'($urandom_range(0, cnt - 1));
    else it.index = 5'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < 3) it.op = OP_UNUSED;
    else if (roll < (filling ? 70 : 30)) it.op = skt_pkg::OP_INSERT;
    else if (roll < (filling ? 85 : 65)) it.op = skt_pkg::OP_GET;
    else it.op = skt_pkg::OP_REMOVE;
    return it;
  endfunction

  initial begin
    logic [skt_pkg::CapW-1:0] phase_cap [NumPhases];
    phase_cap[0] = 6'd32;
    phase_cap[1] = 6'd1;
    phase_cap[2] = 6'd63;
    phase_cap[3] = 6'($urandom_range(2, 31));
    phase_cap[4] = 6'd32;
    phase_cap[5] = 6'($urandom_range(0, 63));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(skt_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000, 5'd0);
    send_op(skt_pkg::OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 5'd31);
    send_op(skt_pkg::OP_INSERT, 32'h8000_0000, 32'h1234_5678, 5'd0);
    send_op(skt_pkg::OP_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5, 5'd0);
    send_op(skt_pkg::OP_INSERT, 32'h0000_0000, 32'h5a5a_5a5a, 5'd0);
    send_op(skt_pkg::OP_GET, 32'h0, 32'h0, 5'd0);
    send_op(skt_pkg::OP_GET, 32'h0, 32'h0, 5'd4);
    send_op(skt_pkg::OP_GET, 32'h0, 32'h0, 5'd2);
    send_op(skt_pkg::OP_GET, 32'h0, 32'h0, 5'd5);
    send_op(skt_pkg::OP_GET, 32'hffff_ffff, 32'hffff_ffff, 5'd31);
    send_op(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 5'd31);
    send_op(skt_pkg::OP_REMOVE, 32'h0, 32'h0, 5'd2);
    send_op(skt_pkg::OP_REMOVE, 32'h0, 32'h0, 5'd31);
    send_op(skt_pkg::OP_REMOVE, 32'h0, 32'h0, 5'd0);

    // The table now holds more entries than the new capacity allows.
    wait_drained();
    write_capacity(6'd2);
    send_op(skt_pkg::OP_INSERT, 32'h0000_0010, 32'h0000_0001, 5'd0);
    send_op(skt_pkg::OP_REMOVE, 32'h0, 32'h0, 5'd2);
    send_op(skt_pkg::OP_INSERT, 32'h0000_0011, 32'h0000_0002, 5'd0);
    send_op(skt_pkg::OP_REMOVE, 32'h0, 32'h0, 5'd0);
    send_op(skt_pkg::OP_INSERT, 32'hffff_fff0, 32'h0000_0003, 5'd0);

    wait_drained();
    write_capacity(6'd0);
    send_op(skt_pkg::OP_INSERT, 32'h0000_0020, 32'h0000_0004, 5'd0);

    wait_drained();
    write_capacity(6'd63);
    send_op(skt_pkg::OP_GET, 32'h0, 32'h0, 5'd1);
    send_op(skt_pkg::OP_INSERT, 32'h0000_0001, 32'h0000_0005, 5'd0);

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      write_capacity(phase_cap[ph]);
      case (ph / 2)
        0: begin
          tx_idle_pct = 12;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 12;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 1 || ph == 4) hold_req <= !hold_req;
      for (int unsigned n = 0; n < PhaseItems; n++) send_item(random_item());
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d result items never arrived", sb.pending_results.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
